// ===== rtl/core/bdeq_pkg.sv =====
// Shared types and constants of the bounded double-ended queue.
package bdeq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned CAP_W = 7;
  localparam int unsigned DEFAULT_DEPTH = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_REAR  = 3'd1,
    REQ_DEL_FRONT = 3'd2,
    REQ_DEL_REAR  = 3'd3,
    REQ_PEEK      = 3'd4
  } req_e;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } out_beat_t;

endpackage

// ===== rtl/core/bounded_double_ended_queue_core.sv =====
// Top level of the bounded double-ended queue.
// A result beat appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle unless the output stalls. Front and rear words
// are registered; two ring read ports prefetch their neighbours for the next request.
// Reset: the queue is empty, the capacity is 64 and no result is pending.
// Ring contents are not cleared by reset; only live entries are ever shown.
module bounded_double_ended_queue_core #(
  parameter int unsigned DEPTH = bdeq_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bdeq_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bdeq_pkg::in_beat_t         in_beat_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bdeq_pkg::out_beat_t        out_beat_o
);
  import bdeq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [CAP_W-1:0] cap_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [WORD_W-1:0] front_q, front_d;
  logic [WORD_W-1:0] rear_q, rear_d;
  logic out_valid_q;
  out_beat_t out_beat_q, out_beat_d;

  logic accept;
  logic empty_now, full_now, empty_new, full_new, ok;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] nf_addr, pr_addr;
  logic [CW-1:0] pr_off;
  logic [WORD_W-1:0] nf_mem, pr_mem, nf_word, pr_word;
  logic byp_nf_q, byp_pr_q;
  logic [WORD_W-1:0] byp_data_q;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_beat_q;

  assign empty_now = (count_q == '0);
  assign full_now = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(DEPTH));

  assign nf_word = byp_nf_q ? byp_data_q : nf_mem;
  assign pr_word = byp_pr_q ? byp_data_q : pr_mem;

  always_comb begin
    head_d = head_q;
    count_d = count_q;
    front_d = front_q;
    rear_d = rear_q;
    wr_en = 1'b0;
    wr_addr = wrap_add(head_q, count_q);
    ok = 1'b0;
    if (accept) begin
      case (in_beat_i.req_type)
        REQ_INS_FRONT: begin
          if (!full_now) begin
            head_d = wrap_add(head_q, CW'(DEPTH - 1));
            wr_addr = head_d;
            wr_en = 1'b1;
            count_d = count_q + CW'(1);
            front_d = in_beat_i.value;
            if (empty_now) begin
              rear_d = in_beat_i.value;
            end
            ok = 1'b1;
          end
        end
        REQ_INS_REAR: begin
          if (!full_now) begin
            wr_en = 1'b1;
            count_d = count_q + CW'(1);
            rear_d = in_beat_i.value;
            if (empty_now) begin
              front_d = in_beat_i.value;
            end
            ok = 1'b1;
          end
        end
        REQ_DEL_FRONT: begin
          if (!empty_now) begin
            head_d = wrap_add(head_q, CW'(1));
            count_d = count_q - CW'(1);
            front_d = nf_word;
            ok = 1'b1;
          end
        end
        REQ_DEL_REAR: begin
          if (!empty_now) begin
            count_d = count_q - CW'(1);
            rear_d = pr_word;
            ok = 1'b1;
          end
        end
        REQ_PEEK: begin
          ok = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign empty_new = (count_d == '0);
  assign full_new = (CMPW'(count_d) >= CMPW'(cap_q)) || (count_d == CW'(DEPTH));

  assign pr_off = (count_d >= CW'(2)) ? (count_d - CW'(2)) : '0;
  assign nf_addr = wrap_add(head_d, CW'(1));
  assign pr_addr = wrap_add(head_d, pr_off);

  always_comb begin
    out_beat_d.ok = ok;
    out_beat_d.front_value = empty_new ? '1 : front_d;
    out_beat_d.rear_value = empty_new ? '1 : rear_d;
    out_beat_d.is_empty = empty_new;
    out_beat_d.is_full = full_new;
  end

  bdeq_ring #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ring (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (in_beat_i.value),
    .raddr_a_i(nf_addr),
    .raddr_b_i(pr_addr),
    .rdata_a_o(nf_mem),
    .rdata_b_o(pr_mem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      head_q <= '0;
      count_q <= '0;
      out_valid_q <= 1'b0;
      byp_nf_q <= 1'b0;
      byp_pr_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      head_q <= head_d;
      count_q <= count_d;
      byp_nf_q <= wr_en && (wr_addr == nf_addr);
      byp_pr_q <= wr_en && (wr_addr == pr_addr);
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q <= rear_d;
    byp_data_q <= in_beat_i.value;
    if (accept) begin
      out_beat_q <= out_beat_d;
    end
  end

endmodule

// ===== rtl/core/bdeq_ring.sv =====
// Ring storage with one write port and two registered read ports.
module bdeq_ring #(
  parameter int unsigned DEPTH = bdeq_pkg::DEFAULT_DEPTH,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [bdeq_pkg::WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_a_i,
  input  logic [AW-1:0]               raddr_b_i,
  output logic [bdeq_pkg::WORD_W-1:0] rdata_a_o,
  output logic [bdeq_pkg::WORD_W-1:0] rdata_b_o
);
  import bdeq_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/bdeq_checker.sv =====
// Port-level checker for the bounded double-ended queue and its bind.
module bdeq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input bdeq_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bdeq_pkg::out_beat_t out_beat_o
);
  import bdeq_pkg::*;

  logic in_acc;
  logic known_req;

  assign in_acc = in_valid_i && !in_stall_o;
  assign known_req = (in_beat_i.req_type == REQ_INS_FRONT) ||
                     (in_beat_i.req_type == REQ_INS_REAR) ||
                     (in_beat_i.req_type == REQ_DEL_FRONT) ||
                     (in_beat_i.req_type == REQ_DEL_REAR) ||
                     (in_beat_i.req_type == REQ_PEEK);

  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.is_empty |->
      (out_beat_o.front_value == -32'sd1) && (out_beat_o.rear_value == -32'sd1))
    else $error("Empty queue shows a word other than all ones.");

  a_peek_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.req_type == REQ_PEEK) |=> out_valid_o && out_beat_o.ok)
    else $error("Peek beat did not give a successful result next cycle.");

  a_unknown_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !known_req |=> out_valid_o && !out_beat_o.ok)
    else $error("Unknown request reported success.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("Stalled result beat changed or dropped.");

endmodule

bind bounded_double_ended_queue_core bdeq_checker u_bdeq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_beat_i  (in_beat_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_beat_o (out_beat_o)
);
